@@ sv/ipb_pkg.sv @@
// ipb_pkg: number format, fixed-point result type and saturating add
// for the interval polynomial bound block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ipb_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

  // value plus saturation flag from one product or sum
  typedef struct packed {
    logic  sat;
    data_t value;
  } fx_res_t;

  // saturating add, one guard bit
  function automatic fx_res_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    fx_res_t r;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    r.sat = s[DATA_WIDTH] != s[DATA_WIDTH-1];
    if (r.sat) begin
      r.value = s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
    end else begin
      r.value = s[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/interval_polynomial_bound.sv @@
// interval_polynomial_bound: top level, input register, horner interval
// update and result register; depends on ipb_pkg and ipb_fx_mul
`timescale 1ns / 1ps
`default_nettype none

// Bounds a polynomial over the interval [u_low, u_high] by Horner's rule in
// interval arithmetic. Feed coefficients one word at a time, highest degree
// first, and mark the constant term with last_coeff. The interval ends and
// the target range are taken from the first word of each polynomial and
// ignored on the rest. One result word leaves per polynomial, carrying the
// bound pair, the may-contain-zero and may-hit-range flags and a sticky
// overflow flag for any saturated product or sum. All values are signed
// Q16.16; products round toward minus infinity, products and sums saturate.
// The block takes one word every clock cycle: the accumulator update (four
// 32x32 multipliers, a min/max selection and a saturating add) works on the
// word held in the input register and is registered into the accumulators,
// and the update of a last coefficient also loads the result register, from
// which the result is offered. That accumulator loop sets the rate. While a
// result waits in the output register, a new last coefficient is held in the
// input register and the input stalls behind it; other words keep moving.
module interval_polynomial_bound import ipb_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  // coefficient channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire data_t  coeff,
  input  wire         last_coeff,
  input  wire data_t  u_low,
  input  wire data_t  u_high,
  input  wire data_t  target_low,
  input  wire data_t  target_high,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output data_t       min_bound,
  output data_t       max_bound,
  output logic        may_contain_zero,
  output logic        may_hit_range,
  output logic        overflow
);

  // input register
  logic  item_valid;
  data_t item_coeff;
  logic  item_last;
  data_t item_u_low;
  data_t item_u_high;
  data_t item_target_low;
  data_t item_target_high;

  // polynomial state
  data_t lower_acc;
  data_t upper_acc;
  data_t held_u_low;
  data_t held_u_high;
  data_t held_target_low;
  data_t held_target_high;
  logic  expect_first;
  logic  sat_seen;

  // result register, target range kept alongside for the overlap flag
  data_t out_target_low;
  data_t out_target_high;

  logic    in_accept;
  logic    advance;
  fx_res_t p_ll, p_ul, p_lh, p_uh;
  data_t   lo_prod, hi_prod;
  logic    prod_sat;
  data_t   min_a, min_b, max_a, max_b;
  fx_res_t sum_lo, sum_hi;
  data_t   lower_acc_next, upper_acc_next;
  logic    sat_seen_next;
  data_t   target_low_next, target_high_next;

  // a word moves on unless it is a last one and the result slot is full and not being read
  assign advance   = item_valid && (!item_last || !out_valid || out_ready);
  assign in_ready  = !item_valid || advance;
  assign in_accept = in_valid && in_ready;

  // the four end products of the running bounds
  ipb_fx_mul u_mul_ll (.a(lower_acc), .b(held_u_low),  .res(p_ll));
  ipb_fx_mul u_mul_ul (.a(upper_acc), .b(held_u_low),  .res(p_ul));
  ipb_fx_mul u_mul_lh (.a(lower_acc), .b(held_u_high), .res(p_lh));
  ipb_fx_mul u_mul_uh (.a(upper_acc), .b(held_u_high), .res(p_uh));

  always_comb begin
    min_a = (p_ll.value < p_ul.value) ? p_ll.value : p_ul.value;
    min_b = (p_lh.value < p_uh.value) ? p_lh.value : p_uh.value;
    max_a = (p_ll.value > p_ul.value) ? p_ll.value : p_ul.value;
    max_b = (p_lh.value > p_uh.value) ? p_lh.value : p_uh.value;
    if (!held_u_low[DATA_WIDTH-1]) begin
      // nonnegative interval: pick ends by sign, only two products count
      if (lower_acc[DATA_WIDTH-1]) begin
        lo_prod = p_lh.value;
        if (upper_acc[DATA_WIDTH-1]) begin
          hi_prod  = p_ul.value;
          prod_sat = p_lh.sat || p_ul.sat;
        end else begin
          hi_prod  = p_uh.value;
          prod_sat = p_lh.sat || p_uh.sat;
        end
      end else begin
        lo_prod  = p_ll.value;
        hi_prod  = p_uh.value;
        prod_sat = p_ll.sat || p_uh.sat;
      end
    end else begin
      // general case: min and max over all four products
      lo_prod  = (min_a < min_b) ? min_a : min_b;
      hi_prod  = (max_a > max_b) ? max_a : max_b;
      prod_sat = p_ll.sat || p_ul.sat || p_lh.sat || p_uh.sat;
    end

    sum_lo = sat_add(lo_prod, item_coeff);
    sum_hi = sat_add(hi_prod, item_coeff);

    if (expect_first) begin
      // leading coefficient seeds both bounds, nothing multiplied yet
      lower_acc_next   = item_coeff;
      upper_acc_next   = item_coeff;
      sat_seen_next    = 1'b0;
      target_low_next  = item_target_low;
      target_high_next = item_target_high;
    end else begin
      lower_acc_next   = sum_lo.value;
      upper_acc_next   = sum_hi.value;
      sat_seen_next    = sat_seen || prod_sat || sum_lo.sat || sum_hi.sat;
      target_low_next  = held_target_low;
      target_high_next = held_target_high;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      expect_first <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        expect_first <= item_last;
      end
      if (advance && item_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_coeff       <= coeff;
      item_last        <= last_coeff;
      item_u_low       <= u_low;
      item_u_high      <= u_high;
      item_target_low  <= target_low;
      item_target_high <= target_high;
    end
    if (advance) begin
      lower_acc <= lower_acc_next;
      upper_acc <= upper_acc_next;
      sat_seen  <= sat_seen_next;
      if (expect_first) begin
        held_u_low       <= item_u_low;
        held_u_high      <= item_u_high;
        held_target_low  <= item_target_low;
        held_target_high <= item_target_high;
      end
      if (item_last) begin
        min_bound       <= lower_acc_next;
        max_bound       <= upper_acc_next;
        overflow        <= sat_seen_next;
        out_target_low  <= target_low_next;
        out_target_high <= target_high_next;
      end
    end
  end

  // flags from the registered bounds
  assign may_contain_zero = (min_bound <= 0) && (max_bound >= 0);
  assign may_hit_range    = (out_target_high >= min_bound) && (out_target_low <= max_bound);

  // a finished polynomial always yields a result word
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && item_last) |=> out_valid)
    else $error("last coefficient did not produce a result");

  // a finished polynomial rearms for a fresh leading coefficient
  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    (advance && item_last) |=> expect_first)
    else $error("block not rearmed after last coefficient");

  // a lone constant gives equal bounds and no overflow
  a_single_coeff: assert property (@(posedge clk) disable iff (rst)
    (advance && item_last && expect_first)
      |=> (!overflow && (min_bound == max_bound)))
    else $error("single coefficient result is wrong");

endmodule

`default_nettype wire

@@ sv/ipb_fx_mul.sv @@
// ipb_fx_mul: signed fixed-point product, floor shift by the fraction
// width and saturation to the data range; depends on ipb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ipb_fx_mul import ipb_pkg::*; (
  input  wire data_t   a,
  input  wire data_t   b,
  output fx_res_t      res
);

  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PROD_WIDTH-1:0] shifted;
  logic                         fits;

  always_comb begin
    prod    = PROD_WIDTH'(a) * PROD_WIDTH'(b);
    // arithmetic shift drops low bits, i.e. rounds toward minus infinity
    shifted = prod >>> FRAC_BITS;
    fits    = (&shifted[PROD_WIDTH-1:DATA_WIDTH-1]) || !(|shifted[PROD_WIDTH-1:DATA_WIDTH-1]);
    res.sat = !fits;
    if (fits) begin
      res.value = shifted[DATA_WIDTH-1:0];
    end else begin
      res.value = shifted[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
    end
  end

endmodule

`default_nettype wire
